/* sv/xkc_pkg.sv */
`default_nettype none

package xkc_pkg;

	localparam int KEY_BYTES = 5;
	localparam logic [7:0] JUMP_OPCODE = 8'hEB;

	localparam int BYTE_W = 8;
	localparam int KIDX_W = 4;
	localparam int CFG_W = 16;
	localparam int HPOS_W = 17;

	localparam logic [CFG_W-1:0] GAP_RESET = 16'd16;
	localparam logic [CFG_W-1:0] SLOT_RESET = 16'd5;

	typedef enum logic [0:0] {
		REG_GAP_BYTES  = 1'b0,
		REG_SLOT_BYTES = 1'b1
	} reg_idx_t;

	typedef logic [KEY_BYTES-1:0][BYTE_W-1:0] key_arr_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              in_heap;
		logic              end_of_scan;
	} in_item_t;

	typedef struct packed {
		logic [CFG_W-1:0]  gap;
		logic [HPOS_W-1:0] period;
	} cfg_t;

	function automatic logic [HPOS_W-1:0] period_of(logic [CFG_W-1:0] gap,
			logic [CFG_W-1:0] slot);
		logic [CFG_W-1:0] slot_eff;
		slot_eff = (slot < CFG_W'(KEY_BYTES)) ? CFG_W'(KEY_BYTES) : slot;
		return HPOS_W'(gap) + HPOS_W'(slot_eff);
	endfunction

endpackage

`default_nettype wire

/* sv/xkc_ifs.sv */
`default_nettype none

interface xkc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       in_heap;
	logic       end_of_scan;

	modport source (output valid, data_byte, in_heap, end_of_scan, input ready);
	modport sink (input valid, data_byte, in_heap, end_of_scan, output ready);
endinterface

interface xkc_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] key_index;
	logic [7:0] key_byte;
	logic       last_key;

	modport source (output valid, key_index, key_byte, last_key, input ready);
	modport sink (input valid, key_index, key_byte, last_key, output ready);
endinterface

interface xkc_cfg_if;
	logic              valid;
	logic              ready;
	xkc_pkg::reg_idx_t index;
	logic [15:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/xor_keyshare_collector.sv */
// Rebuilds a 5-byte key from XOR shares in a byte stream of code-region
// bytes followed by heap-region bytes. One byte is taken per cycle; the
// whole per-byte update (jump/length compare, window flag shift, XOR into
// the key bytes, heap period counter) settles in the cycle the byte is
// accepted. The byte flagged end_of_scan is folded in, then the key is
// copied to a report buffer and sent as 5 beats, index 0 first, last_key
// on the final one, while the stream state clears for the next scan.
// Input bytes keep flowing during a report; an end_of_scan byte stalls
// only if the previous report still has beats left beyond the current
// cycle. Register writes (gap_bytes at index 0, slot_bytes at index 1)
// are taken at once and belong between scans.
`default_nettype none

module xor_keyshare_collector (
	input  wire logic clk,
	input  wire logic arst_n,
	xkc_in_if.sink    in_ch,
	xkc_out_if.source out_ch,
	xkc_cfg_if.sink   cfg
);
	import xkc_pkg::*;

	cfg_t     cfg_cur;
	in_item_t item;
	key_arr_t key_snap;
	logic     rep_free;
	logic     accept;

	assign item.data_byte   = in_ch.data_byte;
	assign item.in_heap     = in_ch.in_heap;
	assign item.end_of_scan = in_ch.end_of_scan;

	assign in_ch.ready = rep_free || !in_ch.end_of_scan;
	assign accept      = in_ch.valid && in_ch.ready;

	xkc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_cur)
	);

	xkc_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg      (cfg_cur),
		.key_snap (key_snap)
	);

	xkc_report u_report (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept && item.end_of_scan),
		.key_snap (key_snap),
		.free     (rep_free),
		.out_ch   (out_ch)
	);

endmodule

`default_nettype wire

/* sv/xkc_cfg.sv */
`default_nettype none

module xkc_cfg (
	input  wire logic      clk,
	input  wire logic      arst_n,
	xkc_cfg_if.sink        cfg,
	output xkc_pkg::cfg_t  cfg_out
);
	import xkc_pkg::*;

	logic [CFG_W-1:0]  gap_q;
	logic [CFG_W-1:0]  slot_q;
	logic [HPOS_W-1:0] period_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q    <= GAP_RESET;
			slot_q   <= SLOT_RESET;
			period_q <= period_of(GAP_RESET, SLOT_RESET);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_GAP_BYTES: begin
					gap_q    <= cfg.data;
					period_q <= period_of(cfg.data, slot_q);
				end
				REG_SLOT_BYTES: begin
					slot_q   <= cfg.data;
					period_q <= period_of(gap_q, cfg.data);
				end
				default: begin
					gap_q <= gap_q;
				end
			endcase
		end
	end

	assign cfg_out.gap    = gap_q;
	assign cfg_out.period = period_q;

endmodule

`default_nettype wire

/* sv/xkc_accum.sv */
`default_nettype none

module xkc_accum (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire xkc_pkg::in_item_t item,
	input  wire xkc_pkg::cfg_t     cfg,
	output xkc_pkg::key_arr_t      key_snap
);
	import xkc_pkg::*;

	key_arr_t              key_q;
	logic [KEY_BYTES-1:0]  flags_q;
	logic                  prev_jump_q;
	logic [HPOS_W-1:0]     heap_pos_q;
	logic                  region_q;

	key_arr_t              key_n;
	logic [KEY_BYTES-1:0]  flags_n;
	logic                  prev_jump_n;
	logic [HPOS_W-1:0]     heap_pos_n;
	logic [HPOS_W:0]       diff;
	logic                  in_slot;
	logic [HPOS_W-1:0]     pos_inc;

	assign diff    = {1'b0, heap_pos_q} - (HPOS_W+1)'(cfg.gap);
	assign in_slot = !diff[HPOS_W] && (diff[HPOS_W-1:0] < HPOS_W'(KEY_BYTES));
	assign pos_inc = heap_pos_q + HPOS_W'(1);

	always_comb begin
		key_n       = key_q;
		flags_n     = flags_q;
		prev_jump_n = prev_jump_q;
		heap_pos_n  = heap_pos_q;
		if (item.in_heap) begin
			flags_n     = '0;
			prev_jump_n = 1'b0;
			for (int d = 0; d < KEY_BYTES; d++) begin
				if (in_slot && diff[HPOS_W-1:0] == HPOS_W'(d))
					key_n[d] = key_q[d] ^ item.data_byte;
			end
			heap_pos_n = (pos_inc >= cfg.period) ? '0 : pos_inc;
		end else begin
			heap_pos_n = '0;
			for (int d = 0; d < KEY_BYTES; d++) begin
				if (flags_q[d])
					key_n[d] = key_q[d] ^ item.data_byte;
			end
			for (int d = KEY_BYTES - 1; d > 0; d--)
				flags_n[d] = flags_q[d-1];
			flags_n[0]  = prev_jump_q && (item.data_byte == BYTE_W'(KEY_BYTES));
			prev_jump_n = (item.data_byte == JUMP_OPCODE);
		end
	end

	assign key_snap = key_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q       <= '0;
			flags_q     <= '0;
			prev_jump_q <= 1'b0;
			heap_pos_q  <= '0;
			region_q    <= 1'b0;
		end else if (accept) begin
			if (item.end_of_scan) begin
				key_q       <= '0;
				flags_q     <= '0;
				prev_jump_q <= 1'b0;
				heap_pos_q  <= '0;
				region_q    <= 1'b0;
			end else begin
				key_q       <= key_n;
				flags_q     <= flags_n;
				prev_jump_q <= prev_jump_n;
				heap_pos_q  <= heap_pos_n;
				region_q    <= item.in_heap;
			end
		end
	end

`ifndef SYNTHESIS
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.end_of_scan |=> key_q == '0 && flags_q == '0 && heap_pos_q == '0)
		else $error("stream state not cleared after final byte");
	a_heap_no_windows: assert property (@(posedge clk) disable iff (!arst_n)
		region_q |-> flags_q == '0 && !prev_jump_q)
		else $error("code windows open in heap region");
	a_code_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!region_q |-> heap_pos_q == '0)
		else $error("heap position kept in code region");
`endif

endmodule

`default_nettype wire

/* sv/xkc_report.sv */
`default_nettype none

module xkc_report (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire xkc_pkg::key_arr_t key_snap,
	output logic                   free,
	xkc_out_if.source              out_ch
);
	import xkc_pkg::*;

	key_arr_t          rep_q;
	logic [KIDX_W-1:0] idx_q;
	logic              busy_q;
	logic              beat;
	logic              last_beat;

	assign last_beat = idx_q == KIDX_W'(KEY_BYTES - 1);
	assign beat      = busy_q && out_ch.ready;
	assign free      = !busy_q || (beat && last_beat);

	assign out_ch.valid     = busy_q;
	assign out_ch.key_index = idx_q;
	assign out_ch.key_byte  = rep_q[0];
	assign out_ch.last_key  = last_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (beat) begin
			busy_q <= !last_beat;
			idx_q  <= last_beat ? '0 : idx_q + KIDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rep_q <= key_snap;
		end else if (beat) begin
			for (int i = 0; i < KEY_BYTES - 1; i++)
				rep_q[i] <= rep_q[i+1];
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < KIDX_W'(KEY_BYTES))
		else $error("report index out of range");
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && idx_q == '0)
		else $error("report did not start at key byte zero");
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		beat && !last_beat && !load |=> busy_q && idx_q == $past(idx_q) + KIDX_W'(1))
		else $error("report index did not advance");
`endif

endmodule

`default_nettype wire
